@@ sv/bpa_pkg.sv @@
// Buddy page allocator: shared types, codes, constants and helper functions.
// No dependencies; imported by bpa_if, buddy_page_allocator and bpa_seq.
`default_nettype none
package bpa_pkg;

   localparam int PAGES_MAX  = 4096;
   localparam int TOP_ORDER  = 10;
   localparam int ORDERS     = TOP_ORDER + 1;
   localparam int PAGE_AW    = $clog2(PAGES_MAX);
   localparam int LINK_W     = PAGE_AW + 1;
   localparam int ORD_W      = 4;
   localparam int META_W     = ORD_W + 1;
   localparam int MIN_PAGES  = 16;
   localparam int PAGE_SHIFT = 12;

   localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(PAGES_MAX);
   localparam logic [31:0] BASE_RESET  = 32'h0010_0000;
   localparam logic [12:0] PAGES_RESET = 13'(PAGES_MAX);

   typedef logic [1:0] cmd_type;
   localparam cmd_type CMD_INIT  = 2'd0;
   localparam cmd_type CMD_ALLOC = 2'd1;
   localparam cmd_type CMD_FREE  = 2'd2;
   localparam cmd_type CMD_QUERY = 2'd3;

   typedef logic [2:0] status_type;
   localparam status_type STAT_OK        = 3'd0;
   localparam status_type STAT_NOT_READY = 3'd1;
   localparam status_type STAT_NO_MEMORY = 3'd2;
   localparam status_type STAT_NULL      = 3'd3;
   localparam status_type STAT_UNALIGNED = 3'd4;
   localparam status_type STAT_BELOW     = 3'd5;
   localparam status_type STAT_RANGE     = 3'd6;
   localparam status_type STAT_DOUBLE    = 3'd7;

   localparam logic CSR_BASE  = 1'b0;
   localparam logic CSR_PAGES = 1'b1;

   typedef struct packed {
      logic [31:0] base;
      logic [12:0] pages;
   } cfg_type;

   typedef struct packed {
      logic               we;
      logic [PAGE_AW-1:0] waddr;
      logic [META_W-1:0]  wdata;
      logic [PAGE_AW-1:0] raddr;
   } meta_port_type;

   typedef struct packed {
      logic               we;
      logic [PAGE_AW-1:0] waddr;
      logic [LINK_W-1:0]  wdata;
      logic [PAGE_AW-1:0] raddr;
   } link_port_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_INIT, ST_CLEAR, ST_CARVE, ST_PUT, ST_PUT_LINK, ST_TAKE, ST_TAKE_LINK,
      ST_ALLOC, ST_SPLIT, ST_FREE, ST_FREE_IDX, ST_FREE_META, ST_MERGE, ST_MERGE_META,
      ST_MERGE_STEP, ST_QUERY, ST_QUERY_META, ST_FINISH
   } state_type;

   function automatic logic [LINK_W-1:0] order_weight(input logic [ORD_W-1:0] ord);
      return LINK_W'(1) << ord;
   endfunction

   // largest aligned block starting at idx that still fits in the zone
   function automatic logic [ORD_W-1:0] carve_order(input logic [LINK_W-1:0] idx,
                                                    input logic [LINK_W-1:0] zone);
      logic [ORD_W-1:0] res;
      logic             found;
      logic [LINK_W:0]  blk;
      res   = '0;
      found = 1'b0;
      for (int o = TOP_ORDER; o > 0; o--) begin
         blk = (LINK_W+1)'(1) << o;
         if (!found && ((idx & (blk[LINK_W-1:0] - LINK_W'(1))) == '0) &&
             ({1'b0, idx} + blk <= {1'b0, zone})) begin
            res   = ORD_W'(o);
            found = 1'b1;
         end
      end
      return res;
   endfunction

endpackage
`default_nettype wire

@@ sv/bpa_if.sv @@
// Request and response channel interfaces of the buddy page allocator.
// Depends on bpa_pkg.
`default_nettype none
interface bpa_req_if import bpa_pkg::*; ();
   logic        valid;
   logic        ready;
   cmd_type     cmd;
   logic [31:0] address;
   logic [15:0] page_number;
   modport source (output valid, cmd, address, page_number, input ready);
   modport sink (input valid, cmd, address, page_number, output ready);
endinterface

interface bpa_rsp_if import bpa_pkg::*; ();
   logic        valid;
   logic        ready;
   status_type  status;
   logic [31:0] page_address;
   logic        page_used;
   logic [12:0] free_count;
   modport source (output valid, status, page_address, page_used, free_count, input ready);
   modport sink (input valid, status, page_address, page_used, free_count, output ready);
endinterface
`default_nettype wire

@@ sv/buddy_page_allocator.sv @@
// Buddy page allocator top level: CSRs, metadata and link RAMs, sequencer.
// Depends on bpa_pkg, bpa_if, bpa_ram and bpa_seq.
//
//  channel  | dir | transfer when    | contents
//  req_chan | in  | valid & ready    | cmd, address, page_number
//  rsp_chan | out | valid & ready    | status, page_address, page_used, free_count
//  csr_*    | in  | csr_we           | csr_index, csr_wdata
//
// One item at a time. Init clears the metadata, then carves the zone into aligned
// blocks; alloc takes a block of the lowest non-empty order and splits it down to
// one page; free checks the address, then merges with free buddies; query reads the
// page metadata. The metadata and link RAMs have registered read data.
// Reset is synchronous; the result register lets the next request in while rsp stalls.
`default_nettype none
module buddy_page_allocator import bpa_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   bpa_req_if.sink          req_chan,
   bpa_rsp_if.source        rsp_chan,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_wdata
);
   cfg_type cfg_ff;
   meta_port_type meta_port;
   link_port_type prev_port, next_port;
   logic [META_W-1:0] meta_rd;
   logic [LINK_W-1:0] prev_rd, next_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base  <= BASE_RESET;
         cfg_ff.pages <= PAGES_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BASE:  cfg_ff.base  <= csr_wdata;
            CSR_PAGES: cfg_ff.pages <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   bpa_ram #(.WIDTH(META_W), .DEPTH(PAGES_MAX)) u_meta (
      .clock(clock), .we(meta_port.we), .waddr(meta_port.waddr), .wdata(meta_port.wdata),
      .raddr(meta_port.raddr), .rdata(meta_rd));

   bpa_ram #(.WIDTH(LINK_W), .DEPTH(PAGES_MAX)) u_prev (
      .clock(clock), .we(prev_port.we), .waddr(prev_port.waddr), .wdata(prev_port.wdata),
      .raddr(prev_port.raddr), .rdata(prev_rd));

   bpa_ram #(.WIDTH(LINK_W), .DEPTH(PAGES_MAX)) u_next (
      .clock(clock), .we(next_port.we), .waddr(next_port.waddr), .wdata(next_port.wdata),
      .raddr(next_port.raddr), .rdata(next_rd));

   bpa_seq u_seq (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .req(req_chan), .rsp(rsp_chan),
      .meta_port(meta_port), .prev_port(prev_port), .next_port(next_port),
      .meta_rd(meta_rd), .prev_rd(prev_rd), .next_rd(next_rd));
endmodule
`default_nettype wire

@@ sv/bpa_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none
module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

@@ sv/bpa_seq.sv @@
// Sequencer and list datapath: runs init, alloc, free and query one step a cycle
// over the metadata and link RAMs, except while rsp stalls. Depends on bpa_pkg and bpa_if.
`default_nettype none
module bpa_seq import bpa_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cfg_type       cfg,
   bpa_req_if.sink            req,
   bpa_rsp_if.source          rsp,
   output meta_port_type      meta_port,
   output link_port_type      prev_port,
   output link_port_type      next_port,
   input  wire logic [META_W-1:0] meta_rd,
   input  wire logic [LINK_W-1:0] prev_rd,
   input  wire logic [LINK_W-1:0] next_rd
);
   state_type state_ff, state_in, ret_ff, ret_in;
   logic [31:0] addr_ff, addr_in, zbase_ff, zbase_in;
   logic [15:0] pnum_ff, pnum_in;
   logic [LINK_W-1:0] zpages_ff, zpages_in, ftot_ff, ftot_in;
   logic ready_ff, ready_in;
   logic [LINK_W-1:0] head_ff [ORDERS], head_in [ORDERS];
   logic [LINK_W-1:0] tail_ff [ORDERS], tail_in [ORDERS];
   logic [PAGE_AW-1:0] clr_ff, clr_in;
   logic [LINK_W-1:0] idx_ff, idx_in, pg_ff, pg_in, arg_ff, arg_in, t_ff, t_in;
   logic [ORD_W-1:0] ord_ff, ord_in;
   logic [META_W-1:0] tmeta_ff, tmeta_in;
   logic [19:0] diff_ff, diff_in;
   status_type res_status_ff, res_status_in;
   logic [31:0] res_addr_ff, res_addr_in;
   logic res_used_ff, res_used_in;
   logic rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_addr_ff, rsp_addr_in;
   logic rsp_used_ff, rsp_used_in;
   logic [12:0] rsp_free_ff, rsp_free_in;

   logic [LINK_W-1:0] tail_sel, bud, diff_full;
   logic [ORD_W-1:0] low_ord, carve_ord, meta_ord;
   logic low_found;
   logic [31:0] sub;

   assign tail_sel  = tail_ff[ord_ff];
   assign bud       = idx_ff ^ order_weight(ord_ff);
   assign carve_ord = carve_order(idx_ff, zpages_ff);
   assign meta_ord  = meta_rd[META_W-1:1];
   assign sub       = addr_ff - zbase_ff;
   assign diff_full = diff_ff[LINK_W-1:0];

   always_comb begin
      low_ord   = '0;
      low_found = 1'b0;
      for (int o = TOP_ORDER; o >= 0; o--) begin
         if (!head_ff[o][LINK_W-1]) begin
            low_ord   = ORD_W'(o);
            low_found = 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff; ret_in = ret_ff; addr_in = addr_ff;
      pnum_in = pnum_ff; zbase_in = zbase_ff; zpages_in = zpages_ff; ftot_in = ftot_ff;
      ready_in = ready_ff; head_in = head_ff; tail_in = tail_ff; clr_in = clr_ff;
      idx_in = idx_ff; pg_in = pg_ff; arg_in = arg_ff; t_in = t_ff; ord_in = ord_ff;
      tmeta_in = tmeta_ff; diff_in = diff_ff; res_status_in = res_status_ff;
      res_addr_in = res_addr_ff; res_used_in = res_used_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff; rsp_addr_in = rsp_addr_ff;
      rsp_used_in = rsp_used_ff; rsp_free_in = rsp_free_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               addr_in = req.address; pnum_in = req.page_number;
               res_status_in = STAT_OK; res_addr_in = '0; res_used_in = 1'b0;
               case (req.cmd)
                  CMD_INIT:  state_in = ST_INIT;
                  CMD_ALLOC: state_in = ST_ALLOC;
                  CMD_FREE:  state_in = ST_FREE;
                  default:   state_in = ST_QUERY;
               endcase
            end
         end
         ST_INIT: begin
            for (int o = 0; o < ORDERS; o++) begin
               head_in[o] = LINK_NONE;
               tail_in[o] = LINK_NONE;
            end
            ftot_in = '0; ready_in = 1'b0; zbase_in = cfg.base;
            zpages_in = (cfg.pages > PAGES_RESET) ? PAGES_RESET : cfg.pages;
            clr_in = '0;
            state_in = ST_CLEAR;
         end
         ST_CLEAR: begin
            clr_in = clr_ff + PAGE_AW'(1);
            if (&clr_ff) begin
               if (zpages_ff < LINK_W'(MIN_PAGES)) begin
                  res_status_in = STAT_NOT_READY;
                  state_in = ST_FINISH;
               end else begin
                  idx_in = '0;
                  state_in = ST_CARVE;
               end
            end
         end
         ST_CARVE: begin
            if (idx_ff >= zpages_ff) begin
               ready_in = 1'b1;
               state_in = ST_FINISH;
            end else begin
               ord_in = carve_ord; arg_in = idx_ff;
               idx_in = idx_ff + order_weight(carve_ord);
               ret_in = ST_CARVE; state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            tail_in[ord_ff] = arg_ff;
            t_in = tail_sel;
            ftot_in = ftot_ff + order_weight(ord_ff);
            if (!tail_sel[LINK_W-1]) begin
               state_in = ST_PUT_LINK;
            end else begin
               head_in[ord_ff] = arg_ff;
               state_in = ret_ff;
            end
         end
         ST_PUT_LINK: state_in = ret_ff;
         ST_TAKE: state_in = ST_TAKE_LINK;
         ST_TAKE_LINK: begin
            if (prev_rd[LINK_W-1]) begin
               head_in[ord_ff] = next_rd[LINK_W-1] ? LINK_NONE : next_rd;
            end
            if (next_rd[LINK_W-1]) begin
               tail_in[ord_ff] = prev_rd[LINK_W-1] ? LINK_NONE : prev_rd;
            end
            ftot_in = ftot_ff - order_weight(ord_ff);
            state_in = ret_ff;
         end
         ST_ALLOC: begin
            if (!ready_ff) begin
               res_status_in = STAT_NOT_READY; state_in = ST_FINISH;
            end else if (ftot_ff == '0 || !low_found) begin
               res_status_in = STAT_NO_MEMORY; state_in = ST_FINISH;
            end else begin
               ord_in = low_ord; arg_in = head_ff[low_ord]; pg_in = head_ff[low_ord];
               tmeta_in = '0; ret_in = ST_SPLIT; state_in = ST_TAKE;
            end
         end
         ST_SPLIT: begin
            if (ord_ff == '0) begin
               res_addr_in = zbase_ff + {7'b0, pg_ff, 12'b0};
               state_in = ST_FINISH;
            end else begin
               ord_in = ord_ff - ORD_W'(1);
               arg_in = pg_ff + order_weight(ord_ff - ORD_W'(1));
               ret_in = ST_SPLIT; state_in = ST_PUT;
            end
         end
         ST_FREE: begin
            state_in = ST_FINISH;
            if (!ready_ff) res_status_in = STAT_NOT_READY;
            else if (addr_ff == '0) res_status_in = STAT_NULL;
            else if (addr_ff[PAGE_SHIFT-1:0] != '0) res_status_in = STAT_UNALIGNED;
            else if (addr_ff < zbase_ff) res_status_in = STAT_BELOW;
            else begin
               diff_in = sub[31:PAGE_SHIFT];
               state_in = ST_FREE_IDX;
            end
         end
         ST_FREE_IDX: begin
            if (diff_ff >= {7'b0, zpages_ff}) begin
               res_status_in = STAT_RANGE; state_in = ST_FINISH;
            end else begin
               idx_in = diff_full; state_in = ST_FREE_META;
            end
         end
         ST_FREE_META: begin
            if (meta_rd[0]) begin
               res_status_in = STAT_DOUBLE; state_in = ST_FINISH;
            end else begin
               ord_in = (meta_ord > ORD_W'(TOP_ORDER)) ? ORD_W'(TOP_ORDER) : meta_ord;
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            if (ord_ff >= ORD_W'(TOP_ORDER) || bud >= zpages_ff) begin
               arg_in = idx_ff; ret_in = ST_FINISH; state_in = ST_PUT;
            end else begin
               arg_in = bud; state_in = ST_MERGE_META;
            end
         end
         ST_MERGE_META: begin
            if (!meta_rd[0] || meta_ord != ord_ff) begin
               arg_in = idx_ff; ret_in = ST_FINISH; state_in = ST_PUT;
            end else begin
               tmeta_in = {ord_ff, 1'b0}; ret_in = ST_MERGE_STEP; state_in = ST_TAKE;
            end
         end
         ST_MERGE_STEP: begin
            idx_in = idx_ff & ~order_weight(ord_ff);
            ord_in = ord_ff + ORD_W'(1);
            state_in = ST_MERGE;
         end
         ST_QUERY: begin
            if (!ready_ff) begin
               res_status_in = STAT_NOT_READY; state_in = ST_FINISH;
            end else if (pnum_ff >= {3'b0, zpages_ff}) begin
               res_status_in = STAT_RANGE; state_in = ST_FINISH;
            end else begin
               state_in = ST_QUERY_META;
            end
         end
         ST_QUERY_META: begin
            res_used_in = !meta_rd[0];
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1; rsp_status_in = res_status_ff;
               rsp_addr_in = res_addr_ff; rsp_used_in = res_used_ff;
               rsp_free_in = ftot_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      meta_port = '0;
      prev_port = '0;
      next_port = '0;
      meta_port.raddr = arg_ff[PAGE_AW-1:0];
      prev_port.raddr = arg_ff[PAGE_AW-1:0];
      next_port.raddr = arg_ff[PAGE_AW-1:0];
      case (state_ff)
         ST_CLEAR: begin
            meta_port.we = 1'b1; meta_port.waddr = clr_ff;
         end
         ST_PUT: begin
            meta_port.we = 1'b1; meta_port.waddr = arg_ff[PAGE_AW-1:0];
            meta_port.wdata = {ord_ff, 1'b1};
            prev_port.we = 1'b1; prev_port.waddr = arg_ff[PAGE_AW-1:0];
            prev_port.wdata = tail_sel;
            next_port.we = 1'b1; next_port.waddr = arg_ff[PAGE_AW-1:0];
            next_port.wdata = LINK_NONE;
         end
         ST_PUT_LINK: begin
            next_port.we = 1'b1; next_port.waddr = t_ff[PAGE_AW-1:0];
            next_port.wdata = arg_ff;
         end
         ST_TAKE_LINK: begin
            meta_port.we = 1'b1; meta_port.waddr = arg_ff[PAGE_AW-1:0];
            meta_port.wdata = tmeta_ff;
            next_port.we = !prev_rd[LINK_W-1]; next_port.waddr = prev_rd[PAGE_AW-1:0];
            next_port.wdata = next_rd;
            prev_port.we = !next_rd[LINK_W-1]; prev_port.waddr = next_rd[PAGE_AW-1:0];
            prev_port.wdata = prev_rd;
         end
         ST_FREE_IDX: meta_port.raddr = diff_ff[PAGE_AW-1:0];
         ST_MERGE:    meta_port.raddr = bud[PAGE_AW-1:0];
         ST_QUERY:    meta_port.raddr = pnum_ff[PAGE_AW-1:0];
         default: ;
      endcase
   end

   assign req.ready        = (state_ff == ST_IDLE);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.page_address = rsp_addr_ff;
   assign rsp.page_used    = rsp_used_ff;
   assign rsp.free_count   = rsp_free_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; ret_ff <= ST_IDLE; ready_ff <= 1'b0; ftot_ff <= '0;
         zpages_ff <= '0; zbase_ff <= '0; rsp_valid_ff <= 1'b0;
         for (int o = 0; o < ORDERS; o++) begin
            head_ff[o] <= LINK_NONE;
            tail_ff[o] <= LINK_NONE;
         end
      end else begin
         state_ff <= state_in; ret_ff <= ret_in; ready_ff <= ready_in; ftot_ff <= ftot_in;
         zpages_ff <= zpages_in; zbase_ff <= zbase_in; rsp_valid_ff <= rsp_valid_in;
         head_ff <= head_in; tail_ff <= tail_in;
      end
      addr_ff <= addr_in; pnum_ff <= pnum_in; clr_ff <= clr_in;
      idx_ff <= idx_in; pg_ff <= pg_in; arg_ff <= arg_in; t_ff <= t_in; ord_ff <= ord_in;
      tmeta_ff <= tmeta_in; diff_ff <= diff_in; res_status_ff <= res_status_in;
      res_addr_ff <= res_addr_in; res_used_ff <= res_used_in;
      rsp_status_ff <= rsp_status_in; rsp_addr_ff <= rsp_addr_in;
      rsp_used_ff <= rsp_used_in; rsp_free_ff <= rsp_free_in;
   end
endmodule
`default_nettype wire
